// ===== rtl/tfn_pkg.sv =====
// Shared types and constants for the triangle face normal unit.
`default_nettype none
package tfn_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_EDGE,
    ST_MUL,
    ST_CROSS,
    ST_SHIFT,
    ST_SQUARE,
    ST_SQRT,
    ST_DIV,
    ST_SIGN,
    ST_OUT
  } state_t;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned EDGE_W  = 17;
  localparam int unsigned PROD_W  = 34;
  localparam int unsigned CROSS_W = 35;
  localparam int unsigned MAG_W   = 30;
  localparam int unsigned SUM_W   = 62;
  localparam int unsigned ROOT_W  = 31;
  localparam int unsigned NUM_W   = 45;
  localparam int unsigned NORM_W  = 16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TRI  = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/triangle_face_normal_unit.sv =====
// Top level of the triangle face normal unit: vertex store and bit-serial normal datapath.
`default_nettype none
// Load items only write the vertex store and give no result.
// A triangle item runs through store reads and edges, six serial products, squaring, a bit-serial
// square root and three divisions before its result is valid. A degenerate triangle skips the
// normalization.
// One triangle is worked at a time; no new item is taken until the sequencer is idle again.
// Reset (synchronous, active low) returns the sequencer to idle and drops the output valid.
module triangle_face_normal_unit #(
  parameter int unsigned VERTEX_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [9:0]  in_vertex_index,
  input  wire logic signed [15:0] in_pos_x,
  input  wire logic signed [15:0] in_pos_y,
  input  wire logic signed [15:0] in_pos_z,
  input  wire logic [9:0]  in_corner_a,
  input  wire logic [9:0]  in_corner_b,
  input  wire logic [9:0]  in_corner_c,
  input  wire logic        in_last_triangle,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic             out_degenerate,
  output logic             out_last
);

  localparam int unsigned AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

  // The vertex store: one write port for loads and one registered read port.
  // The store has no reset; an entry read before it was written gives undefined data.
  logic [47:0] mem [VERTEX_DEPTH];
  logic [47:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic rd_ok_r, rd_ok_nxt;

  tfn_pkg::state_t state_r, state_nxt;

  logic [9:0] ca_r, cb_r, cc_r;
  logic       last_r;
  logic signed [15:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  // Edge vectors e1 = B-A and e2 = C-A.
  logic signed [16:0] e1_r [3];
  logic signed [16:0] e2_r [3];
  // Bit-serial multiplier: shift-add over the 17 bits of the multiplier operand.
  logic [5:0]  cnt_r;
  logic [2:0]  term_r;
  logic [33:0] mpa_r;
  logic [16:0] mpb_r;
  logic [33:0] acc_r;
  logic        mneg_r;
  logic signed [33:0] prod_r;
  logic signed [34:0] cr_r [3];
  logic [34:0] cr_mag [3];
  logic        neg_r [3];
  logic [29:0] m_r [3];
  logic [59:0] sq_r;
  logic [61:0] sum_r;
  logic [61:0] rad_r;
  logic [30:0] root_r;
  logic [62:0] rem_r;
  logic [1:0]  comp_r;
  logic [44:0] num_r;
  logic [30:0] drem_r;
  logic [15:0] quo_r;
  logic [15:0] n_r [3];
  logic        deg_r;

  logic accept_in, load_in, tri_in;
  assign accept_in = in_valid && !in_stall;
  assign load_in   = accept_in && (in_command == tfn_pkg::CMD_LOAD);
  assign tri_in    = accept_in && (in_command == tfn_pkg::CMD_TRI);

  always_ff @(posedge clk) begin
    if (load_in && (32'(in_vertex_index) < VERTEX_DEPTH)) begin
      mem[AW'(in_vertex_index)] <= {in_pos_z, in_pos_y, in_pos_x};
    end
    rd_data_r <= mem[rd_addr];
  end

  logic [9:0] rd_idx;
  always_comb begin
    unique case (state_r)
      tfn_pkg::ST_RD_A: rd_idx = ca_r;
      tfn_pkg::ST_RD_B: rd_idx = cb_r;
      default:          rd_idx = cc_r;
    endcase
    rd_addr   = AW'(rd_idx);
    rd_ok_nxt = (32'(rd_idx) < VERTEX_DEPTH);
  end

  always_ff @(posedge clk) begin
    rd_ok_r <= rd_ok_nxt;
  end

  logic [47:0] rd_word;
  assign rd_word = rd_ok_r ? rd_data_r : 48'd0;

  // Next-state logic.
  logic mul_done, sqrt_done, div_done, cross_zero;
  assign mul_done  = (cnt_r == 6'd16);
  assign sqrt_done = (cnt_r == 6'd30);
  assign div_done  = (cnt_r == 6'd44);
  assign cross_zero = (cr_mag[0] == 35'd0) && (cr_mag[1] == 35'd0) && (cr_mag[2] == 35'd0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tfn_pkg::ST_IDLE:   if (tri_in) state_nxt = tfn_pkg::ST_RD_A;
      tfn_pkg::ST_RD_A:   state_nxt = tfn_pkg::ST_RD_B;
      tfn_pkg::ST_RD_B:   state_nxt = tfn_pkg::ST_RD_C;
      tfn_pkg::ST_RD_C:   state_nxt = tfn_pkg::ST_EDGE;
      tfn_pkg::ST_EDGE:   state_nxt = tfn_pkg::ST_MUL;
      tfn_pkg::ST_MUL:    if (mul_done) state_nxt = tfn_pkg::ST_CROSS;
      tfn_pkg::ST_CROSS: begin
        if (term_r == 3'd5) state_nxt = tfn_pkg::ST_SHIFT;
        else                state_nxt = tfn_pkg::ST_MUL;
      end
      tfn_pkg::ST_SHIFT: begin
        if (cross_zero) state_nxt = tfn_pkg::ST_OUT;
        else            state_nxt = tfn_pkg::ST_SQUARE;
      end
      tfn_pkg::ST_SQUARE: if (cnt_r == 6'd29) begin
        if (comp_r == 2'd2) state_nxt = tfn_pkg::ST_SQRT;
      end
      tfn_pkg::ST_SQRT:   if (sqrt_done) state_nxt = tfn_pkg::ST_DIV;
      tfn_pkg::ST_DIV:    if (div_done) state_nxt = tfn_pkg::ST_SIGN;
      tfn_pkg::ST_SIGN: begin
        if (comp_r == 2'd2) state_nxt = tfn_pkg::ST_OUT;
        else                state_nxt = tfn_pkg::ST_DIV;
      end
      tfn_pkg::ST_OUT:    if (!out_valid || !out_stall) state_nxt = tfn_pkg::ST_IDLE;
      default:            state_nxt = tfn_pkg::ST_IDLE;
    endcase
  end

  // Input-side control: the block takes items only when idle.
  always_comb begin
    in_stall = (state_r != tfn_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfn_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Operand selection for each cross product term: e1[i]*e2[j].
  logic [1:0] op_i, op_j;
  always_comb begin
    unique case (term_r)
      3'd0: begin op_i = 2'd1; op_j = 2'd2; end
      3'd1: begin op_i = 2'd2; op_j = 2'd1; end
      3'd2: begin op_i = 2'd2; op_j = 2'd0; end
      3'd3: begin op_i = 2'd0; op_j = 2'd2; end
      3'd4: begin op_i = 2'd0; op_j = 2'd1; end
      default: begin op_i = 2'd1; op_j = 2'd0; end
    endcase
  end

  logic signed [16:0] opa, opb;
  assign opa = e1_r[op_i];
  assign opb = e2_r[op_j];

  // Common shift for all three magnitudes, from the bit length of the largest one.
  logic [34:0] mx;
  logic [5:0]  blen;
  always_comb begin
    mx = cr_mag[0];
    if (cr_mag[1] > mx) mx = cr_mag[1];
    if (cr_mag[2] > mx) mx = cr_mag[2];
    blen = 6'd0;
    for (int k = 0; k < 35; k++) begin
      if (mx[k]) blen = 6'(k + 1);
    end
  end

  // Square root step: two radicand bits per cycle.
  logic [62:0] trial;
  logic [62:0] rem_sh;
  assign rem_sh = {rem_r[60:0], rad_r[61:60]};
  assign trial  = {30'd0, root_r, 2'b01};

  // Divider step: one quotient bit per cycle.
  logic [31:0] drem_sh;
  assign drem_sh = {drem_r, num_r[44]};

  logic [29:0] cur_m;
  assign cur_m = m_r[comp_r];

  // Squaring step: the partial square doubles and takes the magnitude when its next bit is set.
  logic [59:0] sq_step;
  assign sq_step = {sq_r[58:0], 1'b0} + (cur_m[5'd29 - cnt_r[4:0]] ? 60'(cur_m) : 60'd0);

  logic [1:0] comp_inc;
  assign comp_inc = (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;

  always_ff @(posedge clk) begin
    unique case (state_r)
      tfn_pkg::ST_IDLE: begin
        if (tri_in) begin
          ca_r   <= in_corner_a;
          cb_r   <= in_corner_b;
          cc_r   <= in_corner_c;
          last_r <= in_last_triangle;
        end
      end
      tfn_pkg::ST_RD_A: ;
      tfn_pkg::ST_RD_B: begin
        {az_r, ay_r, ax_r} <= rd_word;
      end
      tfn_pkg::ST_RD_C: begin
        {bz_r, by_r, bx_r} <= rd_word;
      end
      tfn_pkg::ST_EDGE: begin
        e1_r[0] <= 17'(bx_r) - 17'(ax_r);
        e1_r[1] <= 17'(by_r) - 17'(ay_r);
        e1_r[2] <= 17'(bz_r) - 17'(az_r);
        e2_r[0] <= 17'($signed(rd_word[15:0]))  - 17'(ax_r);
        e2_r[1] <= 17'($signed(rd_word[31:16])) - 17'(ay_r);
        e2_r[2] <= 17'($signed(rd_word[47:32])) - 17'(az_r);
        term_r  <= 3'd0;
        cnt_r   <= 6'd0;
        acc_r   <= 34'd0;
        mpa_r   <= 34'd0;
        mpb_r   <= 17'd0;
      end
      tfn_pkg::ST_MUL: begin
        if (cnt_r == 6'd0 && mpb_r == 17'd0 && acc_r == 34'd0 && mpa_r == 34'd0) begin
          mpa_r  <= 34'(opa[16] ? -opa : opa);
          mpb_r  <= 17'(opb[16] ? -opb : opb);
          mneg_r <= opa[16] ^ opb[16];
          acc_r  <= 34'd1;
        end else begin
          if (mpb_r[0]) acc_r <= acc_r + mpa_r - ((cnt_r == 6'd0) ? 34'd1 : 34'd0);
          else if (cnt_r == 6'd0) acc_r <= 34'd0;
          mpa_r <= {mpa_r[32:0], 1'b0};
          mpb_r <= {1'b0, mpb_r[16:1]};
          cnt_r <= cnt_r + 6'd1;
        end
      end
      tfn_pkg::ST_CROSS: begin
        if (term_r[0] == 1'b0) begin
          prod_r <= mneg_r ? -$signed(acc_r) : $signed(acc_r);
        end else begin
          cr_r[term_r[2:1]] <= 35'(prod_r) -
                              35'(mneg_r ? -$signed(acc_r) : $signed(acc_r));
        end
        term_r <= term_r + 3'd1;
        cnt_r  <= 6'd0;
        acc_r  <= 34'd0;
        mpa_r  <= 34'd0;
        mpb_r  <= 17'd0;
        if (term_r == 3'd5) begin
          for (int k = 0; k < 3; k++) begin
            neg_r[k] <= 1'b0;
          end
        end
      end
      tfn_pkg::ST_SHIFT: begin
        deg_r <= cross_zero;
        for (int k = 0; k < 3; k++) begin
          if (blen <= 6'd30) m_r[k] <= 30'(cr_mag[k] << (6'd30 - blen));
          else               m_r[k] <= 30'(cr_mag[k] >> (blen - 6'd30));
        end
        sq_r   <= 60'd0;
        sum_r  <= 62'd0;
        comp_r <= 2'd0;
        cnt_r  <= 6'd0;
      end
      tfn_pkg::ST_SQUARE: begin
        // Serial square of one 30-bit magnitude, one bit a cycle, top bit first.
        sq_r  <= sq_step;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd29) begin
          cnt_r <= 6'd0;
          sq_r  <= 60'd0;
          sum_r <= sum_r + 62'(sq_step);
          if (comp_r == 2'd2) begin
            comp_r <= 2'd0;
            rad_r  <= sum_r + 62'(sq_step);
            rem_r  <= 63'd0;
            root_r <= 31'd0;
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end
      end
      tfn_pkg::ST_SQRT: begin
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[29:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[29:0], 1'b0};
        end
        rad_r <= {rad_r[59:0], 2'b00};
        cnt_r <= cnt_r + 6'd1;
        if (sqrt_done) begin
          // The last root bit lands now, so half the final root is the root so far.
          comp_r <= 2'd0;
          cnt_r  <= 6'd0;
          num_r  <= {1'b0, m_r[0], 14'd0} + 45'(root_r[29:0]);
          drem_r <= 31'd0;
          quo_r  <= 16'd0;
        end
      end
      tfn_pkg::ST_DIV: begin
        if (32'(drem_sh) >= 32'(root_r)) begin
          drem_r <= 31'(drem_sh - 32'(root_r));
          quo_r  <= {quo_r[14:0], 1'b1};
        end else begin
          drem_r <= drem_sh[30:0];
          quo_r  <= {quo_r[14:0], 1'b0};
        end
        num_r <= {num_r[43:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
      end
      tfn_pkg::ST_SIGN: begin
        n_r[comp_r] <= neg_r[comp_r] ? (16'd0 - ((quo_r > 16'd16384) ? 16'd16384 : quo_r))
                                     : ((quo_r > 16'd16384) ? 16'd16384 : quo_r);
        comp_r <= comp_inc;
        cnt_r  <= 6'd0;
        num_r  <= {1'b0, m_r[comp_inc], 14'd0} + 45'(root_r[30:1]);
        drem_r <= 31'd0;
        quo_r  <= 16'd0;
      end
      default: ;
    endcase
  end

  // Magnitudes and signs follow the finished cross product components.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cr_mag[k] = cr_r[k][34] ? 35'(-cr_r[k]) : 35'(cr_r[k]);
    end
  end

  logic sgn0, sgn1, sgn2;
  assign sgn0 = cr_r[0][34];
  assign sgn1 = cr_r[1][34];
  assign sgn2 = cr_r[2][34];

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == tfn_pkg::ST_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == tfn_pkg::ST_OUT && (!out_valid || !out_stall)) begin
      out_last       <= last_r;
      out_degenerate <= deg_r;
      out_normal_x   <= deg_r ? 16'sd0 : $signed(sgn0 ? 16'd0 - n_r[0] : n_r[0]);
      out_normal_y   <= deg_r ? 16'sd0 : $signed(sgn1 ? 16'd0 - n_r[1] : n_r[1]);
      out_normal_z   <= deg_r ? 16'sd0 : $signed(sgn2 ? 16'd0 - n_r[2] : n_r[2]);
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the triangle face normal unit.
`timescale 1ns / 1ps
module tb_top;

  // One item on the input channel.
  typedef struct {
    logic       command;
    logic [9:0] vertex_index;
    logic [15:0] pos_x, pos_y, pos_z;
    logic [9:0] corner_a, corner_b, corner_c;
    logic       last_triangle;
  } vtx_item_t;

  // One expected normal.
  typedef struct {
    logic [15:0] nx, ny, nz;
    logic        degenerate;
    logic        last;
  } normal_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = 1'b0;
  logic [9:0] in_vertex_index = '0;
  logic signed [15:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [9:0] in_corner_a = '0, in_corner_b = '0, in_corner_c = '0;
  logic in_last_triangle = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_degenerate, out_last;

  triangle_face_normal_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: positions as loaded, plus a written flag per slot so that the
  // stimulus only names corners that hold real data.
  logic [47:0] vertex_pos [1024];
  bit          vertex_written [1024];
  int          written_list[$];

  vtx_item_t pending_items[$];
  normal_t   expected_normals[$];

  int send_idle_pct = 13;
  int recv_idle_pct = 46;
  int mismatch_count = 0;
  int normals_seen = 0;
  int degenerate_seen = 0;
  int idle_cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Computes the expected unit normal of a triangle item from the stored positions.
  function automatic normal_t face_normal(vtx_item_t it);
    normal_t n;
    longint a[3], b[3], c[3], e1[3], e2[3], cr[3];
    longint unsigned mag[3], mx, sum, r, q;
    logic [47:0] w;
    int len;
    for (int k = 0; k < 3; k++) begin
      w = vertex_pos[k == 0 ? it.corner_a : (k == 1 ? it.corner_b : it.corner_c)];
      for (int j = 0; j < 3; j++) begin
        if (k == 0) a[j] = longint'($signed(w[16*j +: 16]));
        if (k == 1) b[j] = longint'($signed(w[16*j +: 16]));
        if (k == 2) c[j] = longint'($signed(w[16*j +: 16]));
      end
    end
    for (int j = 0; j < 3; j++) begin
      e1[j] = b[j] - a[j];
      e2[j] = c[j] - a[j];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    n.last = it.last_triangle;
    mx = 0;
    for (int j = 0; j < 3; j++) begin
      mag[j] = cr[j] < 0 ? longint'(-cr[j]) : longint'(cr[j]);
      if (mag[j] > mx) mx = mag[j];
    end
    if (mx == 0) begin
      n.nx = '0; n.ny = '0; n.nz = '0;
      n.degenerate = 1'b1;
      return n;
    end
    len = 0;
    while (len < 64 && (mx >> len) != 0) len++;
    sum = 0;
    for (int j = 0; j < 3; j++) begin
      if (len <= 30) mag[j] <<= (30 - len);
      else mag[j] >>= (len - 30);
      sum += mag[j] * mag[j];
    end
    r = int_sqrt(sum);
    if (r == 0) r = 1;
    for (int j = 0; j < 3; j++) begin
      q = (mag[j] * 16384 + (r >> 1)) / r;
      if (q > 16384) q = 16384;
      q = cr[j] < 0 ? (64'd0 - q) : q;
      if (j == 0) n.nx = q[15:0];
      if (j == 1) n.ny = q[15:0];
      if (j == 2) n.nz = q[15:0];
    end
    n.degenerate = 1'b0;
    return n;
  endfunction

  // Queue builders. The predictor state is updated in queue order, which equals
  // the order in which the block accepts items.
  task automatic push_load(int idx, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    vtx_item_t it;
    it = '{default: '0};
    it.command = tfn_pkg::CMD_LOAD;
    it.vertex_index = idx[9:0];
    it.pos_x = x; it.pos_y = y; it.pos_z = z;
    // Triangle fields carry noise on loads; the block must ignore them.
    it.corner_a = 10'($urandom); it.corner_b = 10'($urandom); it.corner_c = 10'($urandom);
    it.last_triangle = 1'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic push_triangle(int ia, int ib, int ic, bit last_flag);
    vtx_item_t it;
    it.command = tfn_pkg::CMD_TRI;
    it.vertex_index = 10'($urandom);
    it.pos_x = 16'($urandom); it.pos_y = 16'($urandom); it.pos_z = 16'($urandom);
    it.corner_a = ia[9:0]; it.corner_b = ib[9:0]; it.corner_c = ic[9:0];
    it.last_triangle = last_flag;
    pending_items.push_back(it);
  endtask

  // Input driver: a new item is presented only once the previous one was taken.
  always @(posedge clk) begin
    vtx_item_t it;
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_items.pop_front();
          in_valid <= 1'b1;
          in_command <= it.command;
          in_vertex_index <= it.vertex_index;
          in_pos_x <= it.pos_x; in_pos_y <= it.pos_y; in_pos_z <= it.pos_z;
          in_corner_a <= it.corner_a; in_corner_b <= it.corner_b;
          in_corner_c <= it.corner_c;
          in_last_triangle <= it.last_triangle;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Acceptance on the input side feeds the predictor, so expectations are formed
  // against the store exactly as the block sees it at that item.
  always @(posedge clk) begin
    vtx_item_t it;
    if (rst_n && in_valid && !in_stall) begin
      it.command = in_command;
      it.vertex_index = in_vertex_index;
      it.pos_x = in_pos_x; it.pos_y = in_pos_y; it.pos_z = in_pos_z;
      it.corner_a = in_corner_a; it.corner_b = in_corner_b; it.corner_c = in_corner_c;
      it.last_triangle = in_last_triangle;
      if (it.command == tfn_pkg::CMD_LOAD)
        vertex_pos[it.vertex_index] = {it.pos_z, it.pos_y, it.pos_x};
      else
        expected_normals.push_back(face_normal(it));
    end
  end

  // Output monitor: compares each taken result with the oldest expectation.
  always @(posedge clk) begin
    normal_t e;
    if (rst_n && out_valid && !out_stall) begin
      normals_seen++;
      if (expected_normals.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result %0d %0d %0d deg=%0b last=%0b",
                   out_normal_x, out_normal_y, out_normal_z, out_degenerate, out_last);
      end else begin
        e = expected_normals.pop_front();
        if (e.degenerate) degenerate_seen++;
        if (out_normal_x !== e.nx || out_normal_y !== e.ny || out_normal_z !== e.nz ||
            out_degenerate !== e.degenerate || out_last !== e.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"ERROR: normal exp %0d %0d %0d deg=%0b last=%0b",
                      " got %0d %0d %0d deg=%0b last=%0b"},
                     $signed(e.nx), $signed(e.ny), $signed(e.nz), e.degenerate, e.last,
                     out_normal_x, out_normal_y, out_normal_z, out_degenerate, out_last);
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_normals.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_written();
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  task automatic note_written(int idx);
    if (!vertex_written[idx]) begin
      vertex_written[idx] = 1;
      written_list.push_back(idx);
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_normals.size() != 0)
      @(posedge clk);
  endtask

  // Builds one random phase of roughly n items, most of them triangles on
  // vertices that were loaded before.
  task automatic random_phase(int n);
    int ia, ib, ic, idx, base;
    for (int k = 0; k < n; k++) begin
      if (written_list.size() < 3 || $urandom_range(99) < 40) begin
        idx = $urandom_range(1023);
        push_load(idx, rand_coord(), rand_coord(), rand_coord());
        note_written(idx);
      end else begin
        case ($urandom_range(9))
          0: begin
            // Repeated corners make a degenerate triangle.
            ia = pick_written();
            push_triangle(ia, ia, pick_written(), 1'($urandom));
          end
          1: begin
            // Three collinear points also cancel the cross product.
            base = $urandom_range(1020);
            push_load(base, 16'd10, 16'd20, 16'd30);
            push_load(base + 1, 16'd20, 16'd40, 16'd60);
            push_load(base + 2, 16'hfff6, 16'hffec, 16'hffe2);
            note_written(base); note_written(base + 1); note_written(base + 2);
            push_triangle(base, base + 1, base + 2, 1'($urandom));
          end
          default: begin
            push_triangle(pick_written(), pick_written(), pick_written(), 1'($urandom));
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: extreme coordinates and index ends, a plain right-handed
    // triangle, a degenerate one, and an extreme-edge triangle.
    push_load(0, 16'h0000, 16'h0000, 16'h0000);
    push_load(1023, 16'h0100, 16'h0000, 16'h0000);
    push_load(1, 16'h0000, 16'h0100, 16'h0000);
    push_load(2, 16'h8000, 16'h8000, 16'h8000);
    push_load(3, 16'h7fff, 16'h7fff, 16'h8000);
    push_load(4, 16'h7fff, 16'h8000, 16'h7fff);
    push_load(5, 16'h0001, 16'h0000, 16'h0000);
    push_load(6, 16'h0000, 16'h0000, 16'h0001);
    for (int i = 0; i <= 6; i++) note_written(i);
    note_written(1023);
    push_triangle(0, 1023, 1, 1'b0);
    push_triangle(0, 1, 1023, 1'b1);
    push_triangle(0, 0, 0, 1'b0);
    push_triangle(2, 3, 4, 1'b1);
    push_triangle(0, 5, 6, 1'b0);
    push_triangle(1023, 2, 3, 1'b0);
    push_triangle(5, 1023, 2, 1'b1);
    wait_drained();

    send_idle_pct = 13; recv_idle_pct = 46;
    random_phase(490);
    wait_drained();
    send_idle_pct = 46; recv_idle_pct = 13;
    random_phase(490);
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(490);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d face normals, %0d of them degenerate, over %0d loaded slots.",
             normals_seen, degenerate_seen, written_list.size());
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
